@@ sv/cmi_pkg.sv @@
// ----------------------------------------------------------------------------
// cmi_pkg: shared types and constants of the cartridge mapper
// Event codes, address range codes, mirroring codes and the event word.
// ----------------------------------------------------------------------------
package cmi_pkg;

    localparam int KIND_W = 3;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BANK_W = 8;

    localparam int A12_FILTER_CYCLES_DEF = 5;
    localparam int FILTER_W              = 3;

    // Event kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_CPU_WRITE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CPU_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_A12_RISE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CPU_QUERY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PPU_QUERY = 3'd4;

    // CPU write ranges, decoded from address bits 15:12.
    localparam logic [3:0] WR_PRG  = 4'h8;
    localparam logic [3:0] WR_CHR  = 4'hA;
    localparam logic [3:0] WR_IRQ  = 4'hC;
    localparam logic [3:0] WR_MIR  = 4'hD;
    localparam logic [3:0] WR_MODE = 4'hE;

    // IRQ register selects, from address bits 1:0 in the IRQ range.
    localparam logic [1:0] IRQ_SEL_LOW     = 2'd0;
    localparam logic [1:0] IRQ_SEL_LATCH   = 2'd1;
    localparam logic [1:0] IRQ_SEL_DISABLE = 2'd2;
    localparam logic [1:0] IRQ_SEL_ENABLE  = 2'd3;

    // CPU 8K windows, from address bits 15:13.
    localparam logic [2:0] WIN_6000 = 3'd3;
    localparam logic [2:0] WIN_8000 = 3'd4;
    localparam logic [2:0] WIN_A000 = 3'd5;
    localparam logic [2:0] WIN_C000 = 3'd6;
    localparam logic [2:0] WIN_E000 = 3'd7;

    localparam logic [BANK_W-1:0] PRG_FIXED_BANK = 8'hFF;
    localparam logic [BANK_W-1:0] PRG_RESET_BASE = 8'hFC;

    // Mirroring modes.
    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE0    = 2'd2;
    localparam logic [1:0] MIR_SINGLE1    = 2'd3;

    // PPU nametable range, from address bits 15:12.
    localparam logic [3:0] PPU_NT_RANGE = 4'h2;

    typedef struct packed {
        logic              wr;
        logic              tick;
        logic              a12;
        logic              cpu_query;
        logic              ppu_query;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } cmi_event_t;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              hit;
        logic              page;
    } cmi_query_t;

endpackage

@@ sv/cmi_bank.sv @@
// ----------------------------------------------------------------------------
// cmi_bank: bank registers and address translation
// Holds the PRG and CHR bank registers and the mirroring mode, takes CPU
// writes to them and answers CPU and PPU map queries from the current state.
// ----------------------------------------------------------------------------
module cmi_bank
    import cmi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmi_event_t ev,
    output cmi_query_t query
);

    logic [BANK_W-1:0] prg_reg [4];
    logic [BANK_W-1:0] chr_reg [8];
    logic [1:0]        mirror_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                prg_reg[i] <= PRG_RESET_BASE + BANK_W'(i);
            end
            for (int i = 0; i < 8; i++) begin
                chr_reg[i] <= BANK_W'(i);
            end
            mirror_reg <= MIR_VERTICAL;
        end else if (ev.wr) begin
            unique case (ev.address[15:12])
                WR_PRG: prg_reg[ev.address[1:0]] <= ev.data;
                WR_CHR: begin
                    if (!ev.address[3]) begin
                        chr_reg[ev.address[2:0]] <= ev.data;
                    end
                end
                WR_MIR: mirror_reg <= ev.data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        query = '0;
        if (ev.cpu_query) begin
            query.hit = 1'b1;
            unique case (ev.address[15:13])
                WIN_6000: query.bank = prg_reg[3];
                WIN_8000: query.bank = prg_reg[0];
                WIN_A000: query.bank = prg_reg[1];
                WIN_C000: query.bank = prg_reg[2];
                WIN_E000: query.bank = PRG_FIXED_BANK;
                default:  query.hit  = 1'b0;
            endcase
        end else if (ev.ppu_query) begin
            if (ev.address[15:13] == 3'd0) begin
                query.bank = chr_reg[ev.address[12:10]];
                query.hit  = 1'b1;
            end else if (ev.address[15:12] == PPU_NT_RANGE) begin
                unique case (mirror_reg)
                    MIR_VERTICAL:   query.page = ev.address[10];
                    MIR_HORIZONTAL: query.page = ev.address[11];
                    MIR_SINGLE0:    query.page = 1'b0;
                    default:        query.page = 1'b1;
                endcase
            end
        end
    end

endmodule

@@ sv/cmi_irq.sv @@
// ----------------------------------------------------------------------------
// cmi_irq: interrupt unit
// Cycle mode counts a 16-bit value down once per CPU tick; scanline mode
// clocks an 8-bit counter on A12 rises that pass the filter.
// ----------------------------------------------------------------------------
module cmi_irq
    import cmi_pkg::*;
#(
    parameter int A12_FILTER_CYCLES = A12_FILTER_CYCLES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmi_event_t ev,
    output logic       irq_next
);

    localparam logic [FILTER_W-1:0] FILTER_LOAD =
        (A12_FILTER_CYCLES > 7) ? 3'd7 : FILTER_W'(A12_FILTER_CYCLES);

    logic [1:0]          mode_reg,    mode_next;
    logic                enable_reg,  enable_next;
    logic                reload_reg,  reload_next;
    logic [FILTER_W-1:0] filter_reg,  filter_next;
    logic [7:0]          low_reg,     low_next;
    logic [7:0]          latch_reg,   latch_next;
    logic                irq_reg;

    logic [15:0] count16;
    logic [15:0] count16_dec;
    logic [7:0]  low_a12;

    assign count16     = {latch_reg, low_reg};
    assign count16_dec = count16 - 16'd1;
    assign low_a12     = (low_reg == 8'd0 || reload_reg) ? latch_reg : low_reg - 8'd1;

    always_comb begin
        mode_next   = mode_reg;
        enable_next = enable_reg;
        reload_next = reload_reg;
        filter_next = filter_reg;
        low_next    = low_reg;
        latch_next  = latch_reg;
        irq_next    = irq_reg;

        if (ev.wr) begin
            if (ev.address[15:12] == WR_IRQ) begin
                unique case (ev.address[1:0])
                    IRQ_SEL_LOW:   low_next = ev.data;
                    IRQ_SEL_LATCH: begin
                        latch_next  = ev.data;
                        reload_next = 1'b1;
                    end
                    IRQ_SEL_DISABLE: enable_next = 1'b0;
                    default:         enable_next = 1'b1;
                endcase
                irq_next = 1'b0;
            end else if (ev.address[15:12] == WR_MODE) begin
                mode_next = ev.data[1:0];
            end
        end else if (ev.tick) begin
            if (filter_reg != '0) begin
                filter_next = filter_reg - FILTER_W'(1);
            end
            if (enable_reg && !mode_reg[1] && count16 != 16'd0) begin
                low_next   = count16_dec[7:0];
                latch_next = count16_dec[15:8];
                if (count16_dec == 16'd0) begin
                    irq_next = 1'b1;
                end
            end
        end else if (ev.a12 && mode_reg[0]) begin
            // The filter blocks rises that come too soon after the last one.
            if (filter_reg == '0 && mode_reg[1]) begin
                low_next    = low_a12;
                reload_next = 1'b0;
                if (low_a12 == 8'd0 && enable_reg) begin
                    irq_next = 1'b1;
                end
            end
            filter_next = FILTER_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= '0;
            enable_reg <= 1'b0;
            reload_reg <= 1'b0;
            filter_reg <= '0;
            low_reg    <= '0;
            latch_reg  <= '0;
            irq_reg    <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            enable_reg <= enable_next;
            reload_reg <= reload_next;
            filter_reg <= filter_next;
            low_reg    <= low_next;
            latch_reg  <= latch_next;
            irq_reg    <= irq_next;
        end
    end

endmodule

@@ sv/cartridge_mapper_irq_banking.sv @@
// ----------------------------------------------------------------------------
// cartridge_mapper_irq_banking: cartridge mapper with banking and IRQ
// Top level: event decode, bank and IRQ units, and the result register.
// ----------------------------------------------------------------------------
// Each input word on the s_ channel is one bus event: a CPU write, a CPU
// cycle tick, a filtered PPU A12 rise, or a CPU or PPU map query. Every
// accepted word yields exactly one result word on the m_ channel, carrying
// the IRQ level after the event and, for queries, the bank translation.
// The event is decoded, applied to the mapper state and its result captured
// in the output register in the cycle it is accepted, so the result is
// offered in the cycle after acceptance. One word is taken per clock while
// the receiver keeps up; the single output register sets that rate, and
// s_ready stays high while it is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and s_ready drops until it is
// taken. Reset (aresetn low, synchronous) empties the output register and
// returns the bank registers, mirroring and IRQ unit to their power-on
// values.
// ----------------------------------------------------------------------------
module cartridge_mapper_irq_banking
    import cmi_pkg::*;
#(
    parameter int A12_FILTER_CYCLES = A12_FILTER_CYCLES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [ADDR_W-1:0] s_address,
    input  logic [DATA_W-1:0] s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_irq_line,
    output logic [BANK_W-1:0] m_bank_number,
    output logic              m_bank_hit,
    output logic              m_nametable_page
);

    logic       s_fire;
    cmi_event_t ev;
    cmi_query_t query;
    logic       irq_next;

    logic              m_valid_reg;
    logic              irq_line_reg;
    logic [BANK_W-1:0] bank_reg;
    logic              hit_reg;
    logic              page_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        ev.wr        = s_fire && (s_kind == KIND_CPU_WRITE);
        ev.tick      = s_fire && (s_kind == KIND_CPU_TICK);
        ev.a12       = s_fire && (s_kind == KIND_A12_RISE);
        ev.cpu_query = s_fire && (s_kind == KIND_CPU_QUERY);
        ev.ppu_query = s_fire && (s_kind == KIND_PPU_QUERY);
        ev.address   = s_address;
        ev.data      = s_data;
    end

    cmi_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ev      (ev),
        .query   (query)
    );

    cmi_irq #(
        .A12_FILTER_CYCLES (A12_FILTER_CYCLES)
    ) u_irq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev),
        .irq_next (irq_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            irq_line_reg <= irq_next;
            bank_reg     <= query.bank;
            hit_reg      <= query.hit;
            page_reg     <= query.page;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_irq_line       = irq_line_reg;
    assign m_bank_number    = bank_reg;
    assign m_bank_hit       = hit_reg;
    assign m_nametable_page = page_reg;

`ifndef SYNTHESIS
    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with an empty output register");

    // A write to the IRQ range acknowledges the interrupt in its own result.
    a_irq_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_kind == KIND_CPU_WRITE && s_address[15:12] == WR_IRQ)
        |=> (m_valid && !m_irq_line))
        else $error("IRQ acknowledge write left the line asserted");

    // Only queries report a bank.
    a_bank_only_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_kind != KIND_CPU_QUERY && s_kind != KIND_PPU_QUERY)
        |=> (!m_bank_hit && m_bank_number == '0 && !m_nametable_page))
        else $error("non-query event returned translation data");

    // Every accepted word is offered in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted word produced no result");
`endif

endmodule
